FILE: rtl/core/cossim_pkg.sv
// cosine similarity package: widths, queue entry type, back-end state codes
// no dependencies; used by every file of the block
package cossim_pkg;

  // element and accumulator widths
  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 2 * ELEM_W;       // signed a*b
  localparam int SQ_W       = 2 * ELEM_W - 1;   // a*a, nonnegative
  localparam int DOT_W      = 42;
  localparam int NORM_W     = 41;

  // root and divide widths
  localparam int ROOT_SCALE = 22;
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int DEN_W      = 2 * ROOT_W;
  localparam int FRAC_SHIFT = 15 + ROOT_SCALE;
  localparam int QUO_W      = 17;
  localparam int DIV_W      = DEN_W + QUO_W - 1;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int STEP_W     = 5;

  // result limits
  localparam logic [ELEM_W-1:0] SIM_POS_MAX = 16'h7fff;
  localparam logic [ELEM_W-1:0] SIM_NEG_MAX = 16'h8000;
  localparam logic [QUO_W-1:0]  QUO_POS_CAP = 17'd32767;
  localparam logic [QUO_W-1:0]  QUO_NEG_CAP = 17'd32768;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [NORM_W-1:0]       norm_a;
    logic [NORM_W-1:0]       norm_b;
  } cossim_sums_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } cossim_state_t;

endpackage

FILE: rtl/core/cossim_ifs.sv
// stream interfaces of the cosine similarity block: element pairs in, results out
// depends on cossim_pkg
interface cossim_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cossim_pkg::ELEM_W-1:0] elem_a;
  logic signed [cossim_pkg::ELEM_W-1:0] elem_b;
  logic                                last;

  modport source(output valid, output elem_a, output elem_b, output last, input ready);
  modport sink(input valid, input elem_a, input elem_b, input last, output ready);
endinterface

interface cossim_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cossim_pkg::ELEM_W-1:0] similarity;
  logic                                zero_norm;

  modport source(output valid, output similarity, output zero_norm, input ready);
  modport sink(input valid, input similarity, input zero_norm, output ready);
endinterface

FILE: rtl/core/cossim_front.sv
// front end: takes element pairs, squares and multiplies, keeps saturating sums
// depends on cossim_pkg and cossim_in_if; pushes finished sums into cossim_queue
module cossim_front (
  input  logic                     clk,
  input  logic                     rst_n,
  cossim_in_if.sink                in_ch,
  input  logic                     q_full,
  output logic                     q_push,
  output cossim_pkg::cossim_sums_t q_data
);

  localparam int PROD_W = cossim_pkg::PROD_W;
  localparam int SQ_W   = cossim_pkg::SQ_W;
  localparam int DOT_W  = cossim_pkg::DOT_W;
  localparam int NORM_W = cossim_pkg::NORM_W;

  logic                     in_ready;
  logic                     acc_en;
  logic signed [PROD_W-1:0] ab_w;
  logic signed [PROD_W-1:0] aa_w;
  logic signed [PROD_W-1:0] bb_w;

  logic                     p_valid_r;
  logic                     p_last_r;
  logic signed [PROD_W-1:0] p_ab_r;
  logic [SQ_W-1:0]          p_aa_r;
  logic [SQ_W-1:0]          p_bb_r;

  logic signed [DOT_W-1:0]  dot_r;
  logic [NORM_W-1:0]        norm_a_r;
  logic [NORM_W-1:0]        norm_b_r;

  logic [DOT_W:0]           dot_sum;
  logic [NORM_W:0]          na_sum;
  logic [NORM_W:0]          nb_sum;
  logic [DOT_W-1:0]         dot_nxt;
  logic [NORM_W-1:0]        norm_a_nxt;
  logic [NORM_W-1:0]        norm_b_nxt;

  // a last pair waiting on a full queue holds the product stage
  assign in_ready    = !(p_valid_r && p_last_r && q_full);
  assign acc_en      = p_valid_r && in_ready;
  assign in_ch.ready = in_ready;

  assign ab_w = in_ch.elem_a * in_ch.elem_b;
  assign aa_w = in_ch.elem_a * in_ch.elem_a;
  assign bb_w = in_ch.elem_b * in_ch.elem_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (in_ready) begin
      p_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      p_ab_r   <= ab_w;
      p_aa_r   <= aa_w[SQ_W-1:0];
      p_bb_r   <= bb_w[SQ_W-1:0];
      p_last_r <= in_ch.last;
    end
  end

  // saturating accumulate
  always_comb begin
    dot_sum = {dot_r[DOT_W-1], dot_r}
            + {{(DOT_W + 1 - PROD_W){p_ab_r[PROD_W-1]}}, p_ab_r};
    na_sum  = {1'b0, norm_a_r} + {{(NORM_W + 1 - SQ_W){1'b0}}, p_aa_r};
    nb_sum  = {1'b0, norm_b_r} + {{(NORM_W + 1 - SQ_W){1'b0}}, p_bb_r};

    if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
      dot_nxt = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
    end else begin
      dot_nxt = dot_sum[DOT_W-1:0];
    end
    norm_a_nxt = na_sum[NORM_W] ? {NORM_W{1'b1}} : na_sum[NORM_W-1:0];
    norm_b_nxt = nb_sum[NORM_W] ? {NORM_W{1'b1}} : nb_sum[NORM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r    <= '0;
      norm_a_r <= '0;
      norm_b_r <= '0;
    end else if (acc_en) begin
      if (p_last_r) begin
        dot_r    <= '0;
        norm_a_r <= '0;
        norm_b_r <= '0;
      end else begin
        dot_r    <= dot_nxt;
        norm_a_r <= norm_a_nxt;
        norm_b_r <= norm_b_nxt;
      end
    end
  end

  assign q_push        = acc_en && p_last_r;
  assign q_data.dot    = dot_nxt;
  assign q_data.norm_a = norm_a_nxt;
  assign q_data.norm_b = norm_b_nxt;

endmodule

FILE: rtl/core/cossim_queue.sv
// short queue of finished vector sums between front end and back end
// depends on cossim_pkg
module cossim_queue #(
  parameter int DEPTH = cossim_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  cossim_pkg::cossim_sums_t push_data,
  output logic                     full,
  input  logic                     pop,
  output cossim_pkg::cossim_sums_t pop_data,
  output logic                     empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cossim_pkg::cossim_sums_t entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: rtl/core/cossim_back.sv
// back end: two bit-serial square roots, root product, serial divide, result register
// depends on cossim_pkg and cossim_out_if; pops sums from cossim_queue
module cossim_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  cossim_pkg::cossim_sums_t q_data,
  output logic                     q_pop,
  cossim_out_if.source             out_ch
);

  localparam int ELEM_W     = cossim_pkg::ELEM_W;
  localparam int DOT_W      = cossim_pkg::DOT_W;
  localparam int NORM_W     = cossim_pkg::NORM_W;
  localparam int RAD_W      = cossim_pkg::RAD_W;
  localparam int ROOT_W     = cossim_pkg::ROOT_W;
  localparam int REM_W      = cossim_pkg::REM_W;
  localparam int DEN_W      = cossim_pkg::DEN_W;
  localparam int QUO_W      = cossim_pkg::QUO_W;
  localparam int DIV_W      = cossim_pkg::DIV_W;
  localparam int STEP_W     = cossim_pkg::STEP_W;
  localparam int ROOT_SCALE = cossim_pkg::ROOT_SCALE;
  localparam int FRAC_SHIFT = cossim_pkg::FRAC_SHIFT;

  // one restoring square root step: brings down two radicand bits
  function automatic logic [REM_W+ROOT_W-1:0] sqrt_step(input logic [REM_W-1:0]  rem,
                                                         input logic [1:0]        pair,
                                                         input logic [ROOT_W-1:0] root);
    logic [REM_W+1:0] rsh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    rsh   = {rem, pair};
    trial = {2'b00, root, 2'b01};
    diff  = rsh - trial;
    if (rsh >= trial) begin
      return {diff[REM_W-1:0], root[ROOT_W-2:0], 1'b1};
    end else begin
      return {rsh[REM_W-1:0], root[ROOT_W-2:0], 1'b0};
    end
  endfunction

  cossim_pkg::cossim_state_t state_r;
  cossim_pkg::cossim_state_t state_nxt;

  logic [STEP_W-1:0]   step_r;
  logic [RAD_W-1:0]    rad_a_r;
  logic [RAD_W-1:0]    rad_b_r;
  logic [REM_W-1:0]    rem_a_r;
  logic [REM_W-1:0]    rem_b_r;
  logic [ROOT_W-1:0]   root_a_r;
  logic [ROOT_W-1:0]   root_b_r;
  logic [DOT_W-1:0]    mag_r;
  logic                neg_r;
  logic                zn_r;
  logic [DIV_W-1:0]    div_rem_r;
  logic [DIV_W-1:0]    div_d_r;
  logic [QUO_W-1:0]    quo_r;

  logic                out_valid_r;
  logic [ELEM_W-1:0]   out_sim_r;
  logic                out_zn_r;

  logic                in_zero;
  logic                sqrt_last;
  logic                div_last;
  logic                out_free;
  logic                out_load;
  logic [REM_W+ROOT_W-1:0] step_a;
  logic [REM_W+ROOT_W-1:0] step_b;
  logic [DEN_W-1:0]    den_w;
  logic [DOT_W-1:0]    dot_u;
  logic [ELEM_W-1:0]   sim_w;

  assign in_zero   = (q_data.norm_a == '0) || (q_data.norm_b == '0);
  assign sqrt_last = (step_r == STEP_W'(cossim_pkg::SQRT_STEPS - 1));
  assign div_last  = (step_r == STEP_W'(cossim_pkg::DIV_STEPS - 1));
  assign out_free  = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cossim_pkg::ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = in_zero ? cossim_pkg::ST_DONE : cossim_pkg::ST_SQRT;
        end
      end
      cossim_pkg::ST_SQRT: begin
        if (sqrt_last) begin
          state_nxt = cossim_pkg::ST_MUL;
        end
      end
      cossim_pkg::ST_MUL: begin
        state_nxt = cossim_pkg::ST_DIV;
      end
      cossim_pkg::ST_DIV: begin
        if (div_last) begin
          state_nxt = cossim_pkg::ST_DONE;
        end
      end
      cossim_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = cossim_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cossim_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      cossim_pkg::ST_IDLE: q_pop    = !q_empty;
      cossim_pkg::ST_DONE: out_load = out_free;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cossim_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == cossim_pkg::ST_SQRT && !sqrt_last) ||
          (state_r == cossim_pkg::ST_DIV && !div_last)) begin
        step_r <= step_r + 1'b1;
      end else begin
        step_r <= '0;
      end
    end
  end

  assign step_a = sqrt_step(rem_a_r, rad_a_r[RAD_W-1:RAD_W-2], root_a_r);
  assign step_b = sqrt_step(rem_b_r, rad_b_r[RAD_W-1:RAD_W-2], root_b_r);
  assign den_w  = root_a_r * root_b_r;
  assign dot_u  = q_data.dot;

  always_ff @(posedge clk) begin
    case (state_r)
      cossim_pkg::ST_IDLE: begin
        rad_a_r  <= {{(RAD_W - NORM_W - ROOT_SCALE){1'b0}}, q_data.norm_a, {ROOT_SCALE{1'b0}}};
        rad_b_r  <= {{(RAD_W - NORM_W - ROOT_SCALE){1'b0}}, q_data.norm_b, {ROOT_SCALE{1'b0}}};
        rem_a_r  <= '0;
        rem_b_r  <= '0;
        root_a_r <= '0;
        root_b_r <= '0;
        neg_r    <= dot_u[DOT_W-1];
        mag_r    <= dot_u[DOT_W-1] ? ('0 - dot_u) : dot_u;
        zn_r     <= in_zero;
        quo_r    <= '0;
      end
      cossim_pkg::ST_SQRT: begin
        {rem_a_r, root_a_r} <= step_a;
        {rem_b_r, root_b_r} <= step_b;
        rad_a_r <= {rad_a_r[RAD_W-3:0], 2'b00};
        rad_b_r <= {rad_b_r[RAD_W-3:0], 2'b00};
      end
      cossim_pkg::ST_MUL: begin
        div_rem_r <= {{(DIV_W - DOT_W - FRAC_SHIFT){1'b0}}, mag_r, {FRAC_SHIFT{1'b0}}};
        div_d_r   <= {den_w, {(QUO_W - 1){1'b0}}};
      end
      cossim_pkg::ST_DIV: begin
        if (div_rem_r >= div_d_r) begin
          div_rem_r <= div_rem_r - div_d_r;
          quo_r     <= {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          quo_r     <= {quo_r[QUO_W-2:0], 1'b0};
        end
        div_d_r <= {1'b0, div_d_r[DIV_W-1:1]};
      end
      default: begin
        quo_r <= quo_r;
      end
    endcase
  end

  // clamp to Q1.15, quotient bit 16 alone already means saturation
  always_comb begin
    if (zn_r) begin
      sim_w = '0;
    end else if (neg_r) begin
      sim_w = (quo_r >= cossim_pkg::QUO_NEG_CAP) ? cossim_pkg::SIM_NEG_MAX
                                                 : ELEM_W'(0) - quo_r[ELEM_W-1:0];
    end else begin
      sim_w = (quo_r >= cossim_pkg::QUO_POS_CAP) ? cossim_pkg::SIM_POS_MAX
                                                 : quo_r[ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sim_r <= sim_w;
      out_zn_r  <= zn_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.similarity = out_sim_r;
  assign out_ch.zero_norm  = out_zn_r;

  // nonzero norms always give roots of at least 2^11
  a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cossim_pkg::ST_MUL |-> (root_a_r != '0 && root_b_r != '0))
    else $error("zero root reached the divider");

  a_zero_norm_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zn_r |-> out_sim_r == '0)
    else $error("zero-norm result carries a nonzero similarity");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == cossim_pkg::ST_DONE)
    else $error("result register loaded outside the done state");

  a_pop_only_idle_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == cossim_pkg::ST_SQRT || state_r == cossim_pkg::ST_DONE))
    else $error("popped sums not taken up by the back end");

endmodule

FILE: rtl/core/cosine_similarity.sv
// cosine similarity top level: front end, sums queue and back end
// depends on cossim_pkg, cossim_ifs, cossim_front, cossim_queue, cossim_back
//
// in_ch carries one transfer per element pair: elem_a, elem_b (signed Q1.15)
// and last, which marks the final pair of the two vectors. out_ch carries one
// transfer per vector pair: similarity (signed Q1.15, truncated toward zero,
// +1.0 saturates to 32767) and zero_norm, set with similarity 0 when either
// vector has zero norm. both channels use valid/ready.
// the front end takes one pair per cycle while in_ch.ready is high: a
// product register, then three saturating sums. on a last pair the sums go
// into a queue of QUEUE_DEPTH entries and are cleared. the back end works
// one vector at a time: a pop, bit-serial square roots (both norms side by
// side), the 32x32 root product, restoring division, then a load of the
// result register. a zero-norm vector skips the roots and the division.
// element pairs keep streaming at one per cycle while the back end works;
// in_ch.ready drops only when a last pair finds the queue full, which
// happens when out_ch stalls or vectors are too short for the back end
// to keep up.
// synchronous reset clears sums, queue, state and the result valid.
module cosine_similarity #(
  parameter int QUEUE_DEPTH = cossim_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  cossim_in_if.sink    in_ch,
  cossim_out_if.source out_ch
);

  // sums handed from front end to back end
  cossim_pkg::cossim_sums_t push_data;
  cossim_pkg::cossim_sums_t pop_data;
  logic                     q_push;
  logic                     q_full;
  logic                     q_pop;
  logic                     q_empty;

  // accumulate stage
  cossim_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (push_data)
  );

  // decouples streaming accumulation from the long divide
  cossim_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // root, divide and result register
  cossim_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
